// File: design/mcpd_pkg.sv
// Shared types and constants of the multi-channel phase dimmer.
package mcpd_pkg;

	localparam int DEF_CHANNELS    = 8;
	localparam int DEF_COUNT_WIDTH = 16;

	localparam int REG_W    = 16;
	localparam int OP_W     = 3;
	localparam int CHAN_W   = 3;
	localparam int MASK_W   = 8;
	localparam int CFG_IDX_W = 3;

	localparam logic [OP_W-1:0] OP_SET_BRIGHT = 3'd0;
	localparam logic [OP_W-1:0] OP_TURN_ON    = 3'd1;
	localparam logic [OP_W-1:0] OP_TURN_OFF   = 3'd2;
	localparam logic [OP_W-1:0] OP_ZERO_CROSS = 3'd3;
	localparam logic [OP_W-1:0] OP_TICK       = 3'd4;
	localparam logic [OP_W-1:0] OP_READ       = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_BRIGHT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BRIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CHAN_EN    = 3'd4;

	localparam logic [REG_W-1:0]  RST_MIN_BRIGHT = 16'd0;
	localparam logic [REG_W-1:0]  RST_MAX_BRIGHT = 16'd100;
	localparam logic [REG_W-1:0]  RST_MIN_DELAY  = 16'd0;
	localparam logic [REG_W-1:0]  RST_MAX_DELAY  = 16'd100;
	localparam logic [MASK_W-1:0] RST_CHAN_EN    = 8'd0;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_EXEC  = 8'b0000_0010,
		ST_PREP  = 8'b0000_0100,
		ST_MUL   = 8'b0000_1000,
		ST_DIV   = 8'b0001_0000,
		ST_ADD   = 8'b0010_0000,
		ST_SWEEP = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

endpackage

// File: design/multi_channel_phase_dimmer.sv
// Multi-channel phase-angle dimmer: sequencer, shared divider and channel sweep.
//
// Input words carry op, channel and value; a word is taken when in_valid is high
// and in_stall is low. Each input word yields exactly one output word (gate_mask,
// brightness, delay_now), offered with out_valid and held while out_stall is high.
// The configuration port takes a register write whenever cfg_valid is high; it is
// always ready and should be written only while the block is idle.
// in_stall is high from the cycle after a word is taken until the result has been
// loaded into the output register; one word is in work at a time.
// Set brightness passes through clamp and multiply, the 16 steps of the shared
// restoring divider that maps brightness to firing delay, and an add step; it goes
// straight from the clamp to the output when the brightness window is empty, and
// skips all of them for a channel that is not present. Zero cross and tick sweep
// the channels one at a time through a single shared compare and increment unit.
// Turn on, turn off and read pass through the execute state.
// If the output word is still stalled when the next result is ready, the sequencer
// waits in its final state until the output register frees up.
// Reset restores the configuration defaults, lowers all gates, disarms and clears
// every channel, and empties the output register.
module multi_channel_phase_dimmer
	import mcpd_pkg::*;
#(
	parameter int CHANNELS    = DEF_CHANNELS,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [OP_W-1:0]         op,
	input  logic [CHAN_W-1:0]       channel,
	input  logic signed [REG_W-1:0] value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [MASK_W-1:0]       gate_mask,
	output logic [REG_W-1:0]        brightness,
	output logic [REG_W-1:0]        delay_now,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [REG_W-1:0]        cfg_data
);

	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CMP_W = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;
	localparam int STEP_W = $clog2(REG_W);

	state_t state_q;

	logic [REG_W-1:0]  min_bright_q, max_bright_q, min_delay_q, max_delay_q;
	logic [MASK_W-1:0] chan_en_q;

	logic [OP_W-1:0]   op_q;
	logic [CH_W-1:0]   idx_q;
	logic signed [REG_W-1:0] val_q;
	logic [CH_W-1:0]   sweep_q;
	logic [STEP_W-1:0] step_q;
	logic              present_q;
	logic              out_valid_q;

	logic [CHANNELS-1:0]    gate_q;
	logic [CHANNELS-1:0]    armed_q;
	logic [COUNT_WIDTH-1:0] tick_q   [CHANNELS];
	logic [REG_W-1:0]       active_q [CHANNELS];
	logic [REG_W-1:0]       saved_q  [CHANNELS];
	logic [REG_W-1:0]       bright_q [CHANNELS];

	logic [REG_W-1:0]  a_mag_q, d_mag_q, den_q, rem_q, quo_q;
	logic              neg_q;
	logic [MASK_W-1:0] gate_mask_q;
	logic [REG_W-1:0]  bright_out_q, delay_out_q;

	logic                   accept;
	logic                   load_out;
	logic                   present;
	logic [CHANNELS-1:0]    en_vec;
	logic [MASK_W-1:0]      mask_d;
	logic [CH_W-1:0]        rd_idx;
	logic [COUNT_WIDTH-1:0] cnt_rd;
	logic [REG_W-1:0]       act_rd;
	logic                   fire;
	logic                   sweep_last;

	logic signed [17:0] v_ext, lo_s, hi_s, v_cl, a_s, d_s, s_s;
	logic [REG_W-1:0]   a_mag, d_mag, s_mag;
	logic               span_zero;
	logic [REG_W:0]     div_sh;
	logic               div_ge;
	logic [REG_W-1:0]   delay_sum;

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign present   = (6'(channel) < 6'(CHANNELS));

	assign out_valid  = out_valid_q;
	assign gate_mask  = gate_mask_q;
	assign brightness = bright_out_q;
	assign delay_now  = delay_out_q;

	// Only the first eight channels have an enable bit; the mask shows only those.
	for (genvar g = 0; g < CHANNELS; g++) begin : g_en
		if (g < MASK_W) begin : g_has
			assign en_vec[g] = chan_en_q[g];
		end else begin : g_none
			assign en_vec[g] = 1'b0;
		end
	end

	for (genvar g = 0; g < MASK_W; g++) begin : g_mask
		if (g < CHANNELS) begin : g_has
			assign mask_d[g] = gate_q[g];
		end else begin : g_none
			assign mask_d[g] = 1'b0;
		end
	end

	// Channel storage is read at one address each cycle: the sweep position
	// while sweeping, otherwise the addressed channel.
	assign rd_idx     = (state_q == ST_SWEEP) ? sweep_q : idx_q;
	assign cnt_rd     = tick_q[rd_idx];
	assign act_rd     = active_q[rd_idx];
	assign fire       = (CMP_W'(cnt_rd) >= CMP_W'(act_rd));
	assign sweep_last = (sweep_q == CH_W'(CHANNELS - 1));

	// Clamp and operand preparation for the brightness to delay mapping.
	always_comb begin
		v_ext = 18'(val_q);
		lo_s  = $signed({2'b00, min_bright_q});
		hi_s  = $signed({2'b00, max_bright_q});
		if (v_ext > hi_s) begin
			v_cl = hi_s;
		end else if (v_ext < lo_s) begin
			v_cl = lo_s;
		end else begin
			v_cl = v_ext;
		end
		a_s = v_cl - lo_s;
		d_s = $signed({2'b00, max_delay_q}) - $signed({2'b00, min_delay_q});
		s_s = hi_s - lo_s;
		a_mag = a_s[17] ? 16'(-a_s) : a_s[15:0];
		d_mag = d_s[17] ? 16'(-d_s) : d_s[15:0];
		s_mag = s_s[17] ? 16'(-s_s) : s_s[15:0];
		span_zero = (s_s == 18'sd0);
	end

	// One restoring division step; the remainder always stays below the divisor.
	assign div_sh    = {rem_q, quo_q[REG_W-1]};
	assign div_ge    = (div_sh >= {1'b0, den_q});
	assign delay_sum = min_delay_q + (neg_q ? 16'(~quo_q + 16'd1) : quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			min_bright_q <= RST_MIN_BRIGHT;
			max_bright_q <= RST_MAX_BRIGHT;
			min_delay_q  <= RST_MIN_DELAY;
			max_delay_q  <= RST_MAX_DELAY;
			chan_en_q    <= RST_CHAN_EN;
			op_q         <= OP_READ;
			idx_q        <= '0;
			val_q        <= '0;
			sweep_q      <= '0;
			step_q       <= '0;
			present_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			gate_q       <= '0;
			armed_q      <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				tick_q[i]   <= '0;
				active_q[i] <= RST_MAX_DELAY;
				saved_q[i]  <= RST_MAX_DELAY;
				bright_q[i] <= RST_MIN_BRIGHT;
			end
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_MIN_BRIGHT: min_bright_q <= cfg_data;
					CFG_MAX_BRIGHT: max_bright_q <= cfg_data;
					CFG_MIN_DELAY:  min_delay_q  <= cfg_data;
					CFG_MAX_DELAY:  max_delay_q  <= cfg_data;
					CFG_CHAN_EN:    chan_en_q    <= cfg_data[MASK_W-1:0];
					default: ;
				endcase
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q      <= op;
						idx_q     <= CH_W'(channel);
						val_q     <= value;
						present_q <= present;
						sweep_q   <= '0;
						case (op)
							OP_SET_BRIGHT: state_q <= present ? ST_PREP : ST_DONE;
							OP_ZERO_CROSS, OP_TICK: state_q <= ST_SWEEP;
							default: state_q <= ST_EXEC;
						endcase
					end
				end
				ST_EXEC: begin
					if (present_q) begin
						case (op_q)
							OP_TURN_ON: active_q[idx_q] <= saved_q[idx_q];
							OP_TURN_OFF: begin
								saved_q[idx_q]  <= act_rd;
								active_q[idx_q] <= min_delay_q;
							end
							default: ;
						endcase
					end
					state_q <= ST_DONE;
				end
				ST_PREP: begin
					bright_q[idx_q] <= v_cl[15:0];
					if (span_zero) begin
						active_q[idx_q] <= min_delay_q;
						state_q         <= ST_DONE;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(REG_W - 1)) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					active_q[idx_q] <= delay_sum;
					state_q         <= ST_DONE;
				end
				ST_SWEEP: begin
					if (en_vec[sweep_q]) begin
						if (op_q == OP_ZERO_CROSS) begin
							armed_q[sweep_q] <= 1'b1;
							gate_q[sweep_q]  <= 1'b0;
							tick_q[sweep_q]  <= '0;
						end else if (armed_q[sweep_q]) begin
							if (fire) begin
								gate_q[sweep_q]  <= 1'b1;
								armed_q[sweep_q] <= 1'b0;
								tick_q[sweep_q]  <= '0;
							end else if (cnt_rd != '1) begin
								tick_q[sweep_q] <= cnt_rd + 1'b1;
							end
						end
					end
					if (sweep_last) begin
						state_q <= ST_DONE;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath work registers and output payload.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_PREP: begin
				a_mag_q <= a_mag;
				d_mag_q <= d_mag;
				den_q   <= s_mag;
				neg_q   <= a_s[17] ^ d_s[17] ^ s_s[17];
			end
			ST_MUL: begin
				{rem_q, quo_q} <= a_mag_q * d_mag_q;
			end
			ST_DIV: begin
				rem_q <= div_ge ? 16'(div_sh - {1'b0, den_q}) : div_sh[REG_W-1:0];
				quo_q <= {quo_q[REG_W-2:0], div_ge};
			end
			default: ;
		endcase
		if (load_out) begin
			gate_mask_q  <= mask_d;
			bright_out_q <= present_q ? bright_q[idx_q] : '0;
			delay_out_q  <= present_q ? act_rd : '0;
		end
	end

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state is not one-hot");

	a_div_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < den_q))
		else $error("divider remainder reached the divisor");

	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && step_q != STEP_W'(REG_W - 1)) |=> (state_q == ST_DIV))
		else $error("divider left before its last step");

	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> (32'(sweep_q) < CHANNELS))
		else $error("sweep index beyond the last channel");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("output word loaded outside the final state");

endmodule
